// File: sv/tlgr_pkg.sv
`default_nettype none

package tlgr_pkg;

    // Framebuffer geometry and line limits.
    localparam int PAGES      = 8;
    localparam int ROW_WIDTH  = 128;
    localparam int MAX_CHARS  = 32;

    // Character cell layout and printable code range.
    localparam int GLYPH_COLS    = 5;
    localparam int CELL_STEP     = GLYPH_COLS + 1;
    localparam int FIRST_CODE    = 32;
    localparam int LAST_CODE     = 126;
    localparam int FALLBACK_CODE = 63;

    // Command queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic {
        OP_BEGIN = 1'b0,
        OP_CHAR  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        K_WRITE  = 2'd0,
        K_CLEAR  = 2'd1,
        K_REJECT = 2'd2
    } t_kind;

    // One queued job: the back emits ncols results from it.
    typedef struct packed {
        t_kind      kind;
        logic [2:0] page;
        logic [6:0] column;
        logic [6:0] glyph;
        logic [2:0] ncols;
    } t_cmd;

    typedef struct packed {
        t_kind      kind;
        logic [2:0] page;
        logic [6:0] column;
        logic [7:0] pixels;
        logic       last;
    } t_result;

    // 5x7 font, one glyph per printable code, first column in the top byte.
    function automatic logic [39:0] font_row(input logic [6:0] idx);
        logic [39:0] r;
        unique case (idx)
            7'd0:  r = 40'h0000000000;
            7'd1:  r = 40'h00005F0000;
            7'd2:  r = 40'h0007000700;
            7'd3:  r = 40'h147F147F14;
            7'd4:  r = 40'h242A7F2A12;
            7'd5:  r = 40'h2313086462;
            7'd6:  r = 40'h3649552250;
            7'd7:  r = 40'h0005030000;
            7'd8:  r = 40'h001C224100;
            7'd9:  r = 40'h0041221C00;
            7'd10: r = 40'h14083E0814;
            7'd11: r = 40'h08083E0808;
            7'd12: r = 40'h0050300000;
            7'd13: r = 40'h0808080808;
            7'd14: r = 40'h0060600000;
            7'd15: r = 40'h2010080402;
            7'd16: r = 40'h3E5149453E;
            7'd17: r = 40'h00427F4000;
            7'd18: r = 40'h4261514946;
            7'd19: r = 40'h2141454B31;
            7'd20: r = 40'h1814127F10;
            7'd21: r = 40'h2745454539;
            7'd22: r = 40'h3C4A494930;
            7'd23: r = 40'h0171090503;
            7'd24: r = 40'h3649494936;
            7'd25: r = 40'h064949291E;
            7'd26: r = 40'h0036360000;
            7'd27: r = 40'h0056360000;
            7'd28: r = 40'h0814224100;
            7'd29: r = 40'h1414141414;
            7'd30: r = 40'h0041221408;
            7'd31: r = 40'h0201510906;
            7'd32: r = 40'h324979413E;
            7'd33: r = 40'h7E1111117E;
            7'd34: r = 40'h7F49494936;
            7'd35: r = 40'h3E41414122;
            7'd36: r = 40'h7F4141221C;
            7'd37: r = 40'h7F49494941;
            7'd38: r = 40'h7F09090901;
            7'd39: r = 40'h3E4149497A;
            7'd40: r = 40'h7F0808087F;
            7'd41: r = 40'h00417F4100;
            7'd42: r = 40'h2040413F01;
            7'd43: r = 40'h7F08142241;
            7'd44: r = 40'h7F40404040;
            7'd45: r = 40'h7F020C027F;
            7'd46: r = 40'h7F0408107F;
            7'd47: r = 40'h3E4141413E;
            7'd48: r = 40'h7F09090906;
            7'd49: r = 40'h3E4151215E;
            7'd50: r = 40'h7F09192946;
            7'd51: r = 40'h4649494931;
            7'd52: r = 40'h01017F0101;
            7'd53: r = 40'h3F4040403F;
            7'd54: r = 40'h1F2040201F;
            7'd55: r = 40'h3F4038403F;
            7'd56: r = 40'h6314081463;
            7'd57: r = 40'h0708700807;
            7'd58: r = 40'h6151494543;
            7'd59: r = 40'h007F414100;
            7'd60: r = 40'h0204081020;
            7'd61: r = 40'h0041417F00;
            7'd62: r = 40'h0402010204;
            7'd63: r = 40'h4040404040;
            7'd64: r = 40'h0001020400;
            7'd65: r = 40'h2054545478;
            7'd66: r = 40'h7F48444438;
            7'd67: r = 40'h3844444420;
            7'd68: r = 40'h384444487F;
            7'd69: r = 40'h3854545418;
            7'd70: r = 40'h087E090102;
            7'd71: r = 40'h081454543C;
            7'd72: r = 40'h7F08040478;
            7'd73: r = 40'h00447D4000;
            7'd74: r = 40'h2040443D00;
            7'd75: r = 40'h7F10284400;
            7'd76: r = 40'h00417F4000;
            7'd77: r = 40'h7C04180478;
            7'd78: r = 40'h7C08040478;
            7'd79: r = 40'h3844444438;
            7'd80: r = 40'h7C14141408;
            7'd81: r = 40'h081414187C;
            7'd82: r = 40'h7C08040408;
            7'd83: r = 40'h4854545420;
            7'd84: r = 40'h043F444020;
            7'd85: r = 40'h3C4040207C;
            7'd86: r = 40'h1C2040201C;
            7'd87: r = 40'h3C4030403C;
            7'd88: r = 40'h4428102844;
            7'd89: r = 40'h0C5050503C;
            7'd90: r = 40'h4464544C44;
            7'd91: r = 40'h0008364100;
            7'd92: r = 40'h00007F0000;
            7'd93: r = 40'h0041360800;
            7'd94: r = 40'h0804081008;
            default: r = 40'h0000000000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/tlgr_if.sv
`default_nettype none

// Input channel: one begin or character request.
interface tlgr_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] line_page;
    logic [7:0] first_col;
    logic [7:0] char_code;

    modport source (output valid, output op, output line_page, output first_col,
                    output char_code, input ready);
    modport sink   (input valid, input op, input line_page, input first_col,
                    input char_code, output ready);
endinterface

// Output channel: one framebuffer request.
interface tlgr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [2:0] page;
    logic [6:0] column;
    logic [7:0] pixels;
    logic       last;

    modport source (output valid, output kind, output page, output column,
                    output pixels, output last, input ready);
    modport sink   (input valid, input kind, input page, input column,
                    input pixels, input last, output ready);
endinterface

`default_nettype wire

// File: sv/text_line_glyph_renderer.sv
`default_nettype none

// Channel   Modport  Direction  Request carries
// i_in      sink     in         op, line_page, first_col, char_code
// o_out     source   out        kind, page, column, pixels, last
//
// With the back idle, a begin request yields one clear or reject request on
// o_out via the queue, the back's command register and the output register;
// a character yields up to five column writes, one per cycle while not stalled.
// The single output register sets the pace: one result per cycle at most.
// Reset is synchronous and active low and empties the queue and the line state.
// The front takes a new request whenever the two-entry command queue has room,
// so it keeps going while the output side is stalled.

module text_line_glyph_renderer
    import tlgr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlgr_in_if.sink     i_in,
    tlgr_out_if.source  o_out
);

    // Front to queue.
    logic    push;
    t_cmd    push_cmd;
    logic    q_full;

    // Queue to back.
    logic    q_valid;
    t_cmd    q_cmd;
    logic    q_pop;

    logic    res_valid;
    t_result res;

    // The front tracks the open line and turns each request into at most one
    // command; requests that produce nothing only update the line state.
    tlgr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in.valid),
        .i_op           (i_in.op),
        .i_line_page    (i_in.line_page),
        .i_first_col    (i_in.first_col),
        .i_char_code    (i_in.char_code),
        .i_q_full       (q_full),
        .o_ready        (i_in.ready),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    tlgr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_cmd)
    );

    // The back walks each command's glyph columns, one per cycle unless stalled,
    // and picks up the next command on the cycle its last result is registered.
    tlgr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .i_res_ready (o_out.ready),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign o_out.valid  = res_valid;
    assign o_out.kind   = res.kind;
    assign o_out.page   = res.page;
    assign o_out.column = res.column;
    assign o_out.pixels = res.pixels;
    assign o_out.last   = res.last;

endmodule

`default_nettype wire

// File: sv/tlgr_front.sv
`default_nettype none

module tlgr_front
    import tlgr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_op,
    input  logic [7:0] i_line_page,
    input  logic [7:0] i_first_col,
    input  logic [7:0] i_char_code,
    input  logic       i_q_full,
    output logic       o_ready,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic       r_line_active, n_line_active;
    logic [2:0] r_page, n_page;
    logic [8:0] r_cell, n_cell;
    logic [5:0] r_chars, n_chars;
    logic       r_ended, n_ended;

    logic       accept;
    logic       bad_begin;
    logic       printable;
    logic [7:0] code_fixed;
    logic [8:0] room;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    assign bad_begin = (i_line_page >= 8'(PAGES)) || (i_first_col >= 8'(ROW_WIDTH));
    assign printable = (i_char_code >= 8'(FIRST_CODE)) && (i_char_code <= 8'(LAST_CODE));
    assign code_fixed = printable ? i_char_code : 8'(FALLBACK_CODE);
    // Columns left before the row end; at least one whenever a glyph is drawn.
    assign room = 9'(ROW_WIDTH) - r_cell;

    always_comb begin
        n_line_active = r_line_active;
        n_page        = r_page;
        n_cell        = r_cell;
        n_chars       = r_chars;
        n_ended       = r_ended;
        o_push        = 1'b0;
        o_cmd.kind    = K_WRITE;
        o_cmd.page    = r_page;
        o_cmd.column  = r_cell[6:0];
        o_cmd.glyph   = 7'(code_fixed - 8'(FIRST_CODE));
        o_cmd.ncols   = (room >= 9'(GLYPH_COLS)) ? 3'(GLYPH_COLS) : room[2:0];
        if (accept) begin
            if (i_op == OP_BEGIN) begin
                o_push       = 1'b1;
                o_cmd.ncols  = 3'd1;
                if (bad_begin) begin
                    n_line_active = 1'b0;
                    o_cmd.kind    = K_REJECT;
                    o_cmd.page    = 3'd0;
                    o_cmd.column  = 7'd0;
                end else begin
                    n_line_active = 1'b1;
                    n_page        = i_line_page[2:0];
                    n_cell        = {1'b0, i_first_col};
                    n_chars       = 6'd0;
                    n_ended       = 1'b0;
                    o_cmd.kind    = K_CLEAR;
                    o_cmd.page    = i_line_page[2:0];
                    o_cmd.column  = i_first_col[6:0];
                end
            end else if (r_line_active && !r_ended) begin
                if (i_char_code == 8'd0) begin
                    n_ended = 1'b1;
                end else if ((r_chars < 6'(MAX_CHARS)) && (r_cell < 9'(ROW_WIDTH))) begin
                    o_push  = 1'b1;
                    n_cell  = r_cell + 9'(CELL_STEP);
                    n_chars = r_chars + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
            r_page        <= 3'd0;
            r_cell        <= 9'd0;
            r_chars       <= 6'd0;
            r_ended       <= 1'b0;
        end else begin
            r_line_active <= n_line_active;
            r_page        <= n_page;
            r_cell        <= n_cell;
            r_chars       <= n_chars;
            r_ended       <= n_ended;
        end
    end

endmodule

`default_nettype wire

// File: sv/tlgr_queue.sv
`default_nettype none

module tlgr_queue
    import tlgr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_data
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/tlgr_back.sv
`default_nettype none

module tlgr_back
    import tlgr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    input  logic    i_res_ready,
    output logic    o_res_valid,
    output t_result o_res
);

    logic        r_busy;
    t_cmd        r_cmd;
    logic [2:0]  r_g;
    logic        r_o_valid;
    t_result     r_o_res;

    logic        out_free;
    logic        emit;
    logic        is_last;
    logic [39:0] glyph;
    logic [7:0]  col_byte;
    t_result     res;

    assign out_free  = !r_o_valid || i_res_ready;
    assign emit      = r_busy && out_free;
    assign is_last   = (r_g == (r_cmd.ncols - 3'd1));
    assign o_cmd_pop = i_cmd_valid && (!r_busy || (emit && is_last));

    assign glyph = font_row(r_cmd.glyph);

    always_comb begin
        case (r_g)
            3'd0:    col_byte = glyph[39:32];
            3'd1:    col_byte = glyph[31:24];
            3'd2:    col_byte = glyph[23:16];
            3'd3:    col_byte = glyph[15:8];
            3'd4:    col_byte = glyph[7:0];
            default: col_byte = 8'd0;
        endcase
    end

    always_comb begin
        res.kind   = r_cmd.kind;
        res.page   = r_cmd.page;
        res.column = r_cmd.column + 7'(r_g);
        res.pixels = (r_cmd.kind == K_WRITE) ? col_byte : 8'd0;
        res.last   = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_busy <= 1'b1;
            end else if (emit && is_last) begin
                r_busy <= 1'b0;
            end
            if (out_free) begin
                r_o_valid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
            r_g   <= 3'd0;
        end else if (emit) begin
            r_g <= r_g + 3'd1;
        end
        if (emit) begin
            r_o_res <= res;
        end
    end

    assign o_res_valid = r_o_valid;
    assign o_res       = r_o_res;

endmodule

`default_nettype wire

// File: sv/tlgr_checker.sv
`default_nettype none

module tlgr_checker
    import tlgr_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [1:0] i_kind,
    input logic [2:0] i_page,
    input logic [6:0] i_column,
    input logic [7:0] i_pixels,
    input logic       i_last
);

    // A stalled result stays offered.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result dropped while stalled");

    // Reset empties the output side.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result offered right after reset");

    // Clear and reject results stand alone and carry no pixels.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == K_CLEAR || i_kind == K_REJECT)
        |-> i_last && (i_pixels == 8'd0))
        else $error("clear or reject result malformed");

    // Reject results address page zero, column zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_kind == K_REJECT) |-> (i_page == 3'd0) && (i_column == 7'd0))
        else $error("reject result addresses a column");

    // Glyph columns of one character follow each other without a gap.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && (i_kind == K_WRITE) && !i_last
        |=> i_valid && (i_kind == K_WRITE) && (i_page == $past(i_page))
            && (i_column == $past(i_column) + 7'd1))
        else $error("glyph column sequence broken");

endmodule

bind text_line_glyph_renderer tlgr_checker u_tlgr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_out.valid),
    .i_ready  (o_out.ready),
    .i_kind   (o_out.kind),
    .i_page   (o_out.page),
    .i_column (o_out.column),
    .i_pixels (o_out.pixels),
    .i_last   (o_out.last)
);

`default_nettype wire
